// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the top level of the flow hash block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// The condition must hold in the same cycle as the trigger.
`define ASSERT_SAME_CYCLE(label, clk, rst_n, trig, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (expr)) \
        else $error(msg);
// The condition must hold in the cycle after the trigger.
`define ASSERT_NEXT_CYCLE(label, clk, rst_n, trig, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (expr)) \
        else $error(msg);
`else
`define ASSERT_SAME_CYCLE(label, clk, rst_n, trig, expr, msg)
`define ASSERT_NEXT_CYCLE(label, clk, rst_n, trig, expr, msg)
`endif

`endif

// ===== rtl/core/ifh_pkg.sv =====
// Package with the types, constants and hash step of the IPv4 flow hash block.
package ifh_pkg;

    // FNV-1 64-bit constants; the prime is 2**40 + 0x1b3.
    localparam logic [63:0] HASH_SEED      = 64'hcbf29ce484222325;
    localparam logic [63:0] HASH_MUL_LO    = 64'h00000000000001b3;
    localparam int          HASH_MUL_SHIFT = 40;

    // Frame offsets, counted from the first byte of the Ethernet header.
    localparam logic [6:0] IP_START   = 7'd14;
    localparam logic [6:0] PROTO_AT   = 7'd23;
    localparam logic [6:0] ADDR_FIRST = 7'd26;
    localparam logic [6:0] ADDR_LAST  = 7'd33;
    localparam logic [6:0] POS_MAX    = 7'd127;

    // Header field values.
    localparam logic [3:0] IPV4_VERSION = 4'd4;
    localparam logic [3:0] IHL_MIN      = 4'd5;
    localparam logic [7:0] PROTO_TCP    = 8'd6;
    localparam logic [7:0] PROTO_UDP    = 8'd17;
    localparam logic [2:0] PORT_BYTES   = 3'd4;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NOT_IPV4  = 3'd1,
        ST_BAD_PROTO = 3'd2,
        ST_SHORT     = 3'd3,
        ST_BAD_IHL   = 3'd4
    } t_status;

    // Fold requests and frame outcome for one accepted byte.
    typedef struct packed {
        logic        last;
        t_status     status;
        logic        req0_vld;
        logic [7:0]  req0_byte;
        logic        req1_vld;
        logic [7:0]  req1_byte;
    } t_fold_req;

    // Finish stage contents: hash so far plus at most one byte still to fold.
    typedef struct packed {
        logic        vld;
        t_status     status;
        logic [63:0] hash;
        logic        pend_vld;
        logic [7:0]  pend_byte;
    } t_fin;

    // One FNV-1 step: multiply by the prime as a shift plus a narrow product,
    // then xor the byte.
    function automatic logic [63:0] fnv_fold(input logic [63:0] h, input logic [7:0] b);
        logic [63:0] prod;
        prod = (h << HASH_MUL_SHIFT) + (h * HASH_MUL_LO);
        return prod ^ {56'd0, b};
    endfunction

endpackage

// ===== rtl/core/ifh_frame_if.sv =====
// Handshake channel that carries frame bytes into the block.
interface ifh_frame_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       last_byte;

    modport source (output valid, output frame_byte, output last_byte, input ready);
    modport sink (input valid, input frame_byte, input last_byte, output ready);
endinterface

// ===== rtl/core/ifh_result_if.sv =====
// Handshake channel that carries flow hash results out of the block.
interface ifh_result_if;
    logic        valid;
    logic        ready;
    logic [63:0] flow_hash;
    logic [2:0]  status;

    modport source (output valid, output flow_hash, output status, input ready);
    modport sink (input valid, input flow_hash, input status, output ready);
endinterface

// ===== rtl/core/ifh_parse.sv =====
// Frame parser: tracks the byte position, header checks and port window.
module ifh_parse
    import ifh_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    output t_fold_req  o_req
);

    logic [6:0] r_pos;
    logic [3:0] r_hw;
    logic [7:0] r_proto;
    t_status    r_err;
    logic [2:0] r_ports;

    logic [6:0] n_pos;
    logic [3:0] n_hw;
    logic [7:0] n_proto;
    t_status    n_err;
    logic [2:0] n_ports;

    logic [6:0] w_start;
    logic [6:0] w_stop;
    logic       w_addr_hit;
    logic       w_port_hit;
    t_status    w_status;

    // Header field capture and first-error tracking.
    always_comb begin
        n_hw    = r_hw;
        n_proto = r_proto;
        n_err   = r_err;
        if (r_pos == IP_START) begin
            n_hw = i_byte[3:0];
            if (i_byte[7:4] != IPV4_VERSION && r_err == ST_OK) begin
                n_err = ST_NOT_IPV4;
            end
        end
        if (r_pos == PROTO_AT) begin
            n_proto = i_byte;
            if (n_err == ST_OK && i_byte != PROTO_TCP && i_byte != PROTO_UDP) begin
                n_err = ST_BAD_PROTO;
            end
        end
    end

    // Address and port windows; the ports follow the IP header.
    assign w_start    = IP_START + {1'b0, n_hw, 2'b00};
    assign w_stop     = w_start + {4'd0, PORT_BYTES};
    assign w_addr_hit = (r_pos >= ADDR_FIRST) && (r_pos <= ADDR_LAST);
    assign w_port_hit = (n_hw >= IHL_MIN) && (r_pos > IP_START) && (r_pos >= w_start)
                        && (r_pos < w_stop) && (r_ports < PORT_BYTES);

    assign n_ports = w_port_hit ? r_ports + 3'd1 : r_ports;
    assign n_pos   = (r_pos < POS_MAX) ? r_pos + 7'd1 : r_pos;

    // Frame outcome, valid when this byte closes the frame.
    always_comb begin
        if (n_err != ST_OK) begin
            w_status = n_err;
        end else if (r_pos < PROTO_AT) begin
            w_status = ST_SHORT;
        end else if (n_hw < IHL_MIN) begin
            w_status = ST_BAD_IHL;
        end else if (n_ports < PORT_BYTES) begin
            w_status = ST_SHORT;
        end else begin
            w_status = ST_OK;
        end
    end

    // Fold requests: the last address byte is followed by the protocol byte.
    always_comb begin
        o_req.last      = i_last;
        o_req.status    = w_status;
        o_req.req0_vld  = w_addr_hit || w_port_hit;
        o_req.req0_byte = i_byte;
        o_req.req1_vld  = (r_pos == ADDR_LAST);
        o_req.req1_byte = r_proto;
    end

    // Frame state; a closing byte returns everything to reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_hw    <= '0;
            r_proto <= '0;
            r_err   <= ST_OK;
            r_ports <= '0;
        end else if (i_accept) begin
            if (i_last) begin
                r_pos   <= '0;
                r_hw    <= '0;
                r_proto <= '0;
                r_err   <= ST_OK;
                r_ports <= '0;
            end else begin
                r_pos   <= n_pos;
                r_hw    <= n_hw;
                r_proto <= n_proto;
                r_err   <= n_err;
                r_ports <= n_ports;
            end
        end
    end

endmodule

// ===== rtl/core/ifh_hash.sv =====
// Hash engine: one FNV step per cycle with a one-byte hold, and the finish stage.
module ifh_hash
    import ifh_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_accept,
    input  t_fold_req i_req,
    input  logic      i_fin_take,
    output t_fin      o_fin
);

    logic [63:0] r_hash;
    logic        r_hold_vld;
    logic [7:0]  r_hold_byte;
    logic        r_fin_vld;
    t_status     r_fin_status;
    logic [63:0] r_fin_hash;
    logic        r_fin_pend_vld;
    logic [7:0]  r_fin_pend_byte;

    logic        w_first_vld;
    logic [7:0]  w_first_byte;
    logic        w_second_vld;
    logic [7:0]  w_second_byte;
    logic [63:0] w_folded;
    logic        w_close;

    // Order the pending bytes: the held byte is older than anything new.
    always_comb begin
        if (r_hold_vld) begin
            w_first_vld   = 1'b1;
            w_first_byte  = r_hold_byte;
            w_second_vld  = i_accept && i_req.req0_vld;
            w_second_byte = i_req.req0_byte;
        end else begin
            w_first_vld   = i_accept && i_req.req0_vld;
            w_first_byte  = i_req.req0_byte;
            w_second_vld  = i_accept && i_req.req1_vld;
            w_second_byte = i_req.req1_byte;
        end
    end

    assign w_folded = w_first_vld ? fnv_fold(r_hash, w_first_byte) : r_hash;
    assign w_close  = i_accept && i_req.last;

    // Running hash and hold byte; a closing byte hands both to the finish stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash     <= HASH_SEED;
            r_hold_vld <= 1'b0;
        end else if (w_close) begin
            r_hash     <= HASH_SEED;
            r_hold_vld <= 1'b0;
        end else begin
            r_hash     <= w_folded;
            r_hold_vld <= w_second_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hold_byte <= w_second_byte;
    end

    // Finish stage, one transaction deep.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_vld <= 1'b0;
        end else if (w_close) begin
            r_fin_vld <= 1'b1;
        end else if (i_fin_take) begin
            r_fin_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_close) begin
            r_fin_status    <= i_req.status;
            r_fin_hash      <= w_folded;
            r_fin_pend_vld  <= w_second_vld;
            r_fin_pend_byte <= w_second_byte;
        end
    end

    // Fields in the order of the finish stage structure.
    assign o_fin = {r_fin_vld, r_fin_status, r_fin_hash, r_fin_pend_vld, r_fin_pend_byte};

endmodule

// ===== rtl/core/ifh_out.sv =====
// Output stage: last pending fold, error masking and the result register.
module ifh_out
    import ifh_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_fin i_fin,
    output logic o_fin_take,
    ifh_result_if.source o_result
);

    logic        r_out_vld;
    logic [63:0] r_out_hash;
    t_status     r_out_status;

    logic [63:0] n_out_hash;

    assign o_fin_take = i_fin.vld && (!r_out_vld || o_result.ready);

    // Fold the remaining byte, and report zero for a frame that is not handled.
    always_comb begin
        if (i_fin.status != ST_OK) begin
            n_out_hash = '0;
        end else if (i_fin.pend_vld) begin
            n_out_hash = fnv_fold(i_fin.hash, i_fin.pend_byte);
        end else begin
            n_out_hash = i_fin.hash;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (o_fin_take) begin
            r_out_vld <= 1'b1;
        end else if (o_result.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_fin_take) begin
            r_out_hash   <= n_out_hash;
            r_out_status <= i_fin.status;
        end
    end

    assign o_result.valid     = r_out_vld;
    assign o_result.flow_hash = r_out_hash;
    assign o_result.status    = r_out_status;

endmodule

// ===== rtl/core/ipv4_flow_hash_fnv1_unit.sv =====
// Top level of the IPv4 five-tuple FNV-1 flow hash block.
//
//  Channel    Direction  Payload                         Transaction
//  i_frame    in         frame_byte[7:0], last_byte      one frame byte
//  o_result   out        flow_hash[63:0], status[2:0]    one result per frame
//
// One frame byte is taken per cycle while input ready is high; the hash engine folds one byte per cycle.
// After the transaction that carries the last byte, the result passes the finish stage and then the result register.
// Reset is synchronous and active low; it clears all frame state at once.
// Input ready drops only while both the finish stage and a stalled result are full.
`include "assert_macros.svh"

module ipv4_flow_hash_fnv1_unit
    import ifh_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    ifh_frame_if.sink    i_frame,
    ifh_result_if.source o_result
);

    logic      w_accept;
    logic      w_fin_take;
    t_fold_req w_req;
    t_fin      w_fin;
    logic      w_close_acc;
    logic      w_full_stall;
    logic      w_err_out;
    logic      w_zero_hash;

    // A new byte is taken whenever the finish stage can take a closing frame.
    assign i_frame.ready = !w_fin.vld || w_fin_take;
    assign w_accept      = i_frame.valid && i_frame.ready;

    ifh_parse u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_byte   (i_frame.frame_byte),
        .i_last   (i_frame.last_byte),
        .o_req    (w_req)
    );

    ifh_hash u_hash (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_req      (w_req),
        .i_fin_take (w_fin_take),
        .o_fin      (w_fin)
    );

    ifh_out u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fin      (w_fin),
        .o_fin_take (w_fin_take),
        .o_result   (o_result)
    );

    // Conditions watched by the checks below.
    assign w_close_acc  = w_accept && i_frame.last_byte;
    assign w_full_stall = w_fin.vld && o_result.valid && !o_result.ready;
    assign w_err_out    = o_result.valid && (o_result.status != ST_OK);
    assign w_zero_hash  = (o_result.flow_hash == 64'd0);

    // A closing byte always lands in the finish stage.
    `ASSERT_NEXT_CYCLE(a_close_fills_fin, i_clk, i_rst_n, w_close_acc, w_fin.vld, "lost close")
    // Back pressure on the input only comes from a full, stalled pipeline.
    `ASSERT_SAME_CYCLE(a_stall_cause, i_clk, i_rst_n, !i_frame.ready, w_full_stall, "stray stall")
    // A frame that is not handled reports a zero hash.
    `ASSERT_SAME_CYCLE(a_err_zero_hash, i_clk, i_rst_n, w_err_out, w_zero_hash, "error hash set")

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the IPv4 five-tuple FNV-1 flow hash block.
module tb
    import ifh_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] HASH_MUL      = 64'h00000100000001b3;
    localparam int          RANDOM_BYTES  = 1600;
    localparam int          MIN_FRAMES    = 24;
    localparam int          HOLD_CYCLES   = 300;
    localparam int          HOLD_AFTER    = 12;
    localparam int          DRAIN_CYCLES  = 20;
    localparam int          CYCLE_LIMIT   = 400000;
    localparam int          FILL_RANDOM   = 0;
    localparam int          FILL_ZERO     = 1;
    localparam int          FILL_ONES     = 2;

    // Tracks the frame in flight and holds the flow hashes still owed by the block.
    class flow_tracker;
        typedef struct {
            logic [63:0] flow_hash;
            t_status     status;
        } t_flow_result;

        logic [6:0]   position;
        logic [63:0]  hash;
        logic [3:0]   ihl;
        logic [7:0]   proto;
        t_status      first_error;
        logic [2:0]   ports_hashed;
        t_flow_result owed_hashes[$];
        int unsigned  failures;

        function new();
            failures = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            position     = '0;
            hash         = HASH_SEED;
            ihl          = '0;
            proto        = '0;
            first_error  = ST_OK;
            ports_hashed = '0;
        endfunction

        // FNV-1 step: multiply by the prime, then xor in the byte.
        function void fnv_step(logic [7:0] b);
            hash = (hash * HASH_MUL) ^ {56'd0, b};
        endfunction

        // Advances the frame state by one accepted byte and owes a result on the last one.
        function void take_byte(logic [7:0] b, logic last);
            int           p;
            int           port_start;
            t_status      st;
            t_flow_result res;
            p = position;
            if (p == IP_START) begin
                ihl = b[3:0];
                if (b[7:4] != IPV4_VERSION && first_error == ST_OK) begin
                    first_error = ST_NOT_IPV4;
                end
            end
            if (p == PROTO_AT) begin
                proto = b;
                if (first_error == ST_OK && b != PROTO_TCP && b != PROTO_UDP) begin
                    first_error = ST_BAD_PROTO;
                end
            end
            if (p >= ADDR_FIRST && p <= ADDR_LAST) begin
                fnv_step(b);
                // The protocol byte is folded right after the last address byte.
                if (p == ADDR_LAST) begin
                    fnv_step(proto);
                end
            end
            if (ihl >= IHL_MIN && p > IP_START) begin
                port_start = IP_START + 4 * ihl;
                if (p >= port_start && p < port_start + 4 && ports_hashed < PORT_BYTES) begin
                    fnv_step(b);
                    ports_hashed++;
                end
            end
            if (position != POS_MAX) begin
                position++;
            end
            if (!last) begin
                return;
            end

            // Errors found along the way take precedence over length checks.
            if (first_error != ST_OK) begin
                st = first_error;
            end else if (p < PROTO_AT) begin
                st = ST_SHORT;
            end else if (ihl < IHL_MIN) begin
                st = ST_BAD_IHL;
            end else if (ports_hashed < PORT_BYTES) begin
                st = ST_SHORT;
            end else begin
                st = ST_OK;
            end
            res.status    = st;
            res.flow_hash = (st == ST_OK) ? hash : '0;
            owed_hashes.push_back(res);
            clear_frame();
        endfunction

        // Compares one result transaction with the oldest owed result.
        function void check_result(logic [63:0] flow_hash, logic [2:0] status);
            t_flow_result exp;
            if (owed_hashes.size() == 0) begin
                $error("unexpected result: flow_hash %h status %0d", flow_hash, status);
                failures++;
                return;
            end
            exp = owed_hashes.pop_front();
            if (flow_hash !== exp.flow_hash) begin
                $error("flow_hash expected %h actual %h", exp.flow_hash, flow_hash);
                failures++;
            end
            if (status !== exp.status) begin
                $error("status expected %0d actual %0d", exp.status, status);
                failures++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    ifh_frame_if  frame_ch ();
    ifh_result_if result_ch ();

    flow_tracker tracker;
    int unsigned cycle_count;
    int unsigned bytes_sent;
    int unsigned frames_sent;
    int unsigned results_taken;
    bit          sender_busy;
    bit          receiver_busy;
    bit          hold_done;

    ipv4_flow_hash_fnv1_unit uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_frame  (frame_ch),
        .o_result (result_ch)
    );

    // Clock generation.
    always #4 i_clk = ~i_clk;

    // Both channels are observed at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n && frame_ch.valid && frame_ch.ready) begin
            tracker.take_byte(frame_ch.frame_byte, frame_ch.last_byte);
        end
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            tracker.check_result(result_ch.flow_hash, result_ch.status);
        end
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Offers one byte, after a random gap while the sender is busy, and waits for its transaction.
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = sender_busy ? $urandom_range(0, 4) : 0;
        repeat (gap) begin
            @(negedge i_clk);
            frame_ch.valid <= 1'b0;
        end
        @(negedge i_clk);
        frame_ch.valid      <= 1'b1;
        frame_ch.frame_byte <= b;
        frame_ch.last_byte  <= last;
        do begin
            @(posedge i_clk);
        end while (!frame_ch.ready);
        bytes_sent++;
    endtask

    // Builds a frame of the given length; shaped frames get the version/IHL and
    // protocol bytes set, the rest is filled per fill mode.
    task automatic send_frame(input int len, input int fill, input bit shaped,
                              input logic [3:0] ver, input logic [3:0] hdr_words,
                              input logic [7:0] proto_val);
        logic [7:0] b;
        for (int i = 0; i < len; i++) begin
            case (fill)
                FILL_ZERO: b = 8'h00;
                FILL_ONES: b = 8'hff;
                default:   b = 8'($urandom_range(0, 255));
            endcase
            if (shaped && i == IP_START) begin
                b = {ver, hdr_words};
            end
            if (shaped && i == PROTO_AT) begin
                b = proto_val;
            end
            send_byte(b, i == len - 1);
        end
        frames_sent++;
        sender_busy = ($urandom_range(0, 3) != 0);
    endtask

    // Result side: random stalls, stretches without stalls, and one long hold-off.
    initial begin
        result_ch.ready = 1'b0;
        receiver_busy   = 1'b1;
        hold_done       = 1'b0;
        results_taken   = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            int gap;
            if (!hold_done && results_taken >= HOLD_AFTER) begin
                hold_done = 1'b1;
                repeat (HOLD_CYCLES) begin
                    @(negedge i_clk);
                    result_ch.ready <= 1'b0;
                end
            end
            gap = receiver_busy ? $urandom_range(0, 4) : 0;
            repeat (gap) begin
                @(negedge i_clk);
                result_ch.ready <= 1'b0;
            end
            @(negedge i_clk);
            result_ch.ready <= 1'b1;
            do begin
                @(posedge i_clk);
            end while (!result_ch.valid);
            results_taken++;
            if (results_taken % 16 == 0) begin
                receiver_busy = ($urandom_range(0, 2) != 0);
            end
        end
    end

    // Reset, directed frames, random frames, then drain and report.
    initial begin
        int          kind;
        logic [3:0]  hdr_words;
        logic [7:0]  proto_val;
        int          extra;
        i_rst_n             = 1'b0;
        frame_ch.valid      = 1'b0;
        frame_ch.frame_byte = '0;
        frame_ch.last_byte  = 1'b0;
        cycle_count         = 0;
        bytes_sent          = 0;
        frames_sent         = 0;
        sender_busy         = 1'b1;
        tracker             = new();
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Frames that end early.
        send_frame(1, FILL_ZERO, 0, IPV4_VERSION, IHL_MIN, PROTO_TCP);
        send_frame(14, FILL_ONES, 0, IPV4_VERSION, IHL_MIN, PROTO_TCP);
        send_frame(20, FILL_RANDOM, 1, IPV4_VERSION, IHL_MIN, PROTO_TCP);
        send_frame(24, FILL_RANDOM, 1, IPV4_VERSION, IHL_MIN, PROTO_TCP);
        send_frame(34, FILL_RANDOM, 1, IPV4_VERSION, IHL_MIN, PROTO_UDP);
        send_frame(36, FILL_RANDOM, 1, IPV4_VERSION, IHL_MIN, PROTO_TCP);
        send_frame(77, FILL_RANDOM, 1, IPV4_VERSION, 4'd15, PROTO_UDP);
        // Header errors, including a version error that masks a protocol error.
        send_frame(15, FILL_RANDOM, 1, 4'd6, IHL_MIN, PROTO_TCP);
        send_frame(24, FILL_RANDOM, 1, IPV4_VERSION, IHL_MIN, 8'd1);
        send_frame(40, FILL_ONES, 1, 4'd5, IHL_MIN, 8'hff);
        send_frame(60, FILL_RANDOM, 1, IPV4_VERSION, 4'd4, PROTO_UDP);
        send_frame(40, FILL_ZERO, 1, IPV4_VERSION, 4'd0, PROTO_TCP);
        // Good frames at the smallest and largest header, and a frame past saturation.
        send_frame(38, FILL_ZERO, 1, IPV4_VERSION, IHL_MIN, PROTO_TCP);
        send_frame(38, FILL_ONES, 1, IPV4_VERSION, IHL_MIN, PROTO_UDP);
        send_frame(78, FILL_RANDOM, 1, IPV4_VERSION, 4'd15, PROTO_TCP);
        send_frame(200, FILL_RANDOM, 1, IPV4_VERSION, 4'd7, PROTO_TCP);

        // Mostly well-formed frames with random content, plus broken ones and noise.
        while (bytes_sent < RANDOM_BYTES || frames_sent < MIN_FRAMES) begin
            kind      = $urandom_range(0, 99);
            hdr_words = ($urandom_range(0, 3) != 0) ? IHL_MIN : 4'($urandom_range(5, 15));
            proto_val = $urandom_range(0, 1) ? PROTO_TCP : PROTO_UDP;
            if (kind < 70) begin
                extra = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 120)
                                                    : $urandom_range(0, 6);
                send_frame(18 + 4 * hdr_words + extra, FILL_RANDOM, 1, IPV4_VERSION,
                           hdr_words, proto_val);
            end else if (kind < 82) begin
                send_frame($urandom_range(1, 17 + 4 * hdr_words), FILL_RANDOM, 1,
                           IPV4_VERSION, hdr_words, proto_val);
            end else if (kind < 88) begin
                send_frame($urandom_range(24, 60), FILL_RANDOM, 1, IPV4_VERSION,
                           4'($urandom_range(0, 4)), proto_val);
            end else begin
                send_frame($urandom_range(1, 90), FILL_RANDOM, 0, IPV4_VERSION,
                           hdr_words, proto_val);
            end
        end
        @(negedge i_clk);
        frame_ch.valid <= 1'b0;

        while (tracker.owed_hashes.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (tracker.failures == 0 && tracker.owed_hashes.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
